// File: hw/rtl/lpht_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the linear probing hash table.
package lpht_pkg;

    localparam int DEF_CAPACITY   = 1021;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 32;

    // Key bits folded into the remainder per cycle of the home slot unit.
    localparam int DIGIT_BITS = 4;

    localparam int OUT_BITS = 32;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUP       = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

endpackage

// File: hw/rtl/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// Linear probing hash table top level: home slot unit, slot memory, sequencer, output register.
//
// Key-value table with open addressing, linear probing and removal marks. After reset the
// block runs a clearing pass that writes every slot (CAPACITY of them, 1021 by default) and
// holds o_stall high until it ends. Each transaction then passes an accept step, the home
// slot (key mod CAPACITY, four key bits per cycle), one read of the slot memory per probed
// slot, and an update step; the sequencer then returns to idle and takes the next one.
// A finished result waits in the output register while the next transaction is accepted.
// Inserts that would push the load above one half are refused with status full.
module linear_probe_hash_table #(
    parameter int CAPACITY   = lpht_pkg::DEF_CAPACITY,
    parameter int KEY_BITS   = lpht_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = lpht_pkg::DEF_VALUE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_op,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic [VALUE_BITS-1:0]         i_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_status,
    output logic [lpht_pkg::OUT_BITS-1:0] o_value_out
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int WW   = KEY_BITS + VALUE_BITS + 2;
    localparam int OW   = lpht_pkg::OUT_BITS;
    localparam int EXTW = (VALUE_BITS > OW) ? VALUE_BITS : OW;

    logic                  mod_start;
    logic                  mod_done;
    logic [AW-1:0]         home;
    lpht_pkg::t_mem_ctl    mem_ctl;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [WW-1:0]         wr_data;
    logic [WW-1:0]         rd_data;
    logic                  out_free;
    logic                  res_load;
    lpht_pkg::t_status     res_status;
    logic [VALUE_BITS-1:0] res_value;
    logic [EXTW-1:0]       res_value_ext;

    logic                  r_valid;
    logic [1:0]            r_status;
    logic [OW-1:0]         r_value_out;

    lpht_mod #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_key   (i_key),
        .o_done  (mod_done),
        .o_home  (home)
    );

    lpht_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (WW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    lpht_ctrl #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_mod_start  (mod_start),
        .i_mod_done   (mod_done),
        .i_home       (home),
        .o_mem_ctl    (mem_ctl),
        .o_rd_addr    (rd_addr),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .i_rd_data    (rd_data),
        .i_out_free   (out_free),
        .o_res_load   (res_load),
        .o_res_status (res_status),
        .o_res_value  (res_value)
    );

    assign out_free      = !r_valid || !i_stall;
    assign res_value_ext = EXTW'(res_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (res_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_status    <= res_status;
            r_value_out <= res_value_ext[OW-1:0];
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_value_out = r_value_out;

endmodule

// File: hw/rtl/lpht_mod.sv
`timescale 1ns / 1ps
// Home slot unit: key modulo the table capacity, one key digit per cycle.
module lpht_mod #(
    parameter int CAPACITY = lpht_pkg::DEF_CAPACITY,
    parameter int KEY_BITS = lpht_pkg::DEF_KEY_BITS,
    localparam int AW      = $clog2(CAPACITY)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [KEY_BITS-1:0] i_key,
    output logic                o_done,
    output logic [AW-1:0]       o_home
);

    localparam int DIG  = lpht_pkg::DIGIT_BITS;
    localparam int NDIG = (KEY_BITS + DIG - 1) / DIG;
    localparam int PADW = NDIG * DIG;
    localparam int CNTW = $clog2(NDIG);
    localparam int TW   = AW + DIG;

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [PADW-1:0] r_shift;
    logic [AW-1:0]   r_rem;
    logic [AW-1:0]   n_rem;

    // The remainder is below the capacity, so the widened value stays below
    // capacity times the digit radix and a binary chain of subtracts reduces it.
    always_comb begin
        logic [TW-1:0] t;
        t = {r_rem, r_shift[PADW-1 -: DIG]};
        for (int k = DIG - 1; k >= 0; k--) begin
            if (t >= (TW'(CAPACITY) << k)) begin
                t = t - (TW'(CAPACITY) << k);
            end
        end
        n_rem = t[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(NDIG - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= PADW'(i_key);
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= r_shift << DIG;
            r_rem   <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_home = r_rem;

endmodule

// File: hw/rtl/lpht_mem.sv
`timescale 1ns / 1ps
// Slot memory with one write port and one registered read port.
module lpht_mem #(
    parameter int DEPTH = lpht_pkg::DEF_CAPACITY,
    parameter int WIDTH = lpht_pkg::DEF_KEY_BITS + lpht_pkg::DEF_VALUE_BITS + 2,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  lpht_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]      i_rd_addr,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [WIDTH-1:0]   i_wr_data,
    output logic [WIDTH-1:0]   o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/lpht_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: clearing pass, probe walk over the slot memory, and update.
module lpht_ctrl #(
    parameter int CAPACITY   = lpht_pkg::DEF_CAPACITY,
    parameter int KEY_BITS   = lpht_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = lpht_pkg::DEF_VALUE_BITS,
    localparam int AW        = $clog2(CAPACITY),
    localparam int WW        = KEY_BITS + VALUE_BITS + 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_op,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_mod_start,
    input  logic                  i_mod_done,
    input  logic [AW-1:0]         i_home,
    output lpht_pkg::t_mem_ctl    o_mem_ctl,
    output logic [AW-1:0]         o_rd_addr,
    output logic [AW-1:0]         o_wr_addr,
    output logic [WW-1:0]         o_wr_data,
    input  logic [WW-1:0]         i_rd_data,
    input  logic                  i_out_free,
    output logic                  o_res_load,
    output lpht_pkg::t_status     o_res_status,
    output logic [VALUE_BITS-1:0] o_res_value
);

    localparam int LIMIT = CAPACITY / 2;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_PROBE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                r_state,    n_state;
    logic [AW-1:0]         r_pos,      n_pos;
    logic [AW-1:0]         r_cnt,      n_cnt;
    logic [AW-1:0]         r_count,    n_count;
    logic [1:0]            r_op,       n_op;
    logic [KEY_BITS-1:0]   r_key,      n_key;
    logic [VALUE_BITS-1:0] r_value,    n_value;
    logic                  r_hit,      n_hit;
    logic [AW-1:0]         r_hit_pos,  n_hit_pos;
    logic [VALUE_BITS-1:0] r_hit_val,  n_hit_val;
    logic                  r_free_ok,  n_free_ok;
    logic [AW-1:0]         r_free_pos, n_free_pos;

    logic                  rd_used;
    logic                  rd_mark;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic [AW-1:0]         next_pos;
    logic                  last_pos;
    logic                  last_probe;

    assign rd_used    = i_rd_data[WW-1];
    assign rd_mark    = i_rd_data[WW-2];
    assign rd_key     = i_rd_data[VALUE_BITS +: KEY_BITS];
    assign rd_val     = i_rd_data[VALUE_BITS-1:0];
    assign last_pos   = (r_pos == AW'(CAPACITY - 1));
    assign next_pos   = last_pos ? '0 : r_pos + 1'b1;
    assign last_probe = (r_cnt == AW'(CAPACITY - 1));

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_count      = r_count;
        n_op         = r_op;
        n_key        = r_key;
        n_value      = r_value;
        n_hit        = r_hit;
        n_hit_pos    = r_hit_pos;
        n_hit_val    = r_hit_val;
        n_free_ok    = r_free_ok;
        n_free_pos   = r_free_pos;
        o_mod_start  = 1'b0;
        o_mem_ctl    = '0;
        o_rd_addr    = r_pos;
        o_wr_addr    = r_pos;
        o_wr_data    = '0;
        o_res_load   = 1'b0;
        o_res_status = lpht_pkg::ST_NOT_FOUND;
        o_res_value  = '0;

        case (r_state)
            S_CLEAR: begin
                o_mem_ctl.wr = 1'b1;
                if (last_pos) begin
                    n_pos   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_op        = i_op;
                    n_key       = i_key;
                    n_value     = i_value;
                    o_mod_start = 1'b1;
                    n_state     = S_HASH;
                end
            end
            S_HASH: begin
                if (i_mod_done) begin
                    o_mem_ctl.rd = 1'b1;
                    o_rd_addr    = i_home;
                    n_pos        = i_home;
                    n_cnt        = '0;
                    n_hit        = 1'b0;
                    n_free_ok    = 1'b0;
                    n_state      = S_PROBE;
                end
            end
            S_PROBE: begin
                // The first slot without a live entry is where an insert lands.
                if (!rd_used && !r_free_ok) begin
                    n_free_ok  = 1'b1;
                    n_free_pos = r_pos;
                end
                if (rd_used && rd_key == r_key) begin
                    n_hit     = 1'b1;
                    n_hit_pos = r_pos;
                    n_hit_val = rd_val;
                    n_state   = S_DONE;
                end else if ((!rd_used && !rd_mark) || last_probe) begin
                    n_state = S_DONE;
                end else begin
                    o_mem_ctl.rd = 1'b1;
                    o_rd_addr    = next_pos;
                    n_pos        = next_pos;
                    n_cnt        = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state    = S_IDLE;
                    case (r_op)
                        lpht_pkg::OP_LOOKUP: begin
                            if (r_hit) begin
                                o_res_status = lpht_pkg::ST_OK;
                                o_res_value  = r_hit_val;
                            end
                        end
                        lpht_pkg::OP_INSERT: begin
                            if (r_hit) begin
                                o_res_status = lpht_pkg::ST_DUP;
                            end else if (r_count >= AW'(LIMIT) || !r_free_ok) begin
                                o_res_status = lpht_pkg::ST_FULL;
                            end else begin
                                o_mem_ctl.wr = 1'b1;
                                o_wr_addr    = r_free_pos;
                                o_wr_data    = {1'b1, 1'b0, r_key, r_value};
                                n_count      = r_count + 1'b1;
                                o_res_status = lpht_pkg::ST_OK;
                            end
                        end
                        lpht_pkg::OP_REMOVE: begin
                            if (r_hit) begin
                                o_mem_ctl.wr = 1'b1;
                                o_wr_addr    = r_hit_pos;
                                o_wr_data    = {1'b0, 1'b1, r_key, r_value};
                                if (r_count != '0) begin
                                    n_count = r_count - 1'b1;
                                end
                                o_res_status = lpht_pkg::ST_OK;
                            end
                        end
                        default: begin
                            o_res_status = lpht_pkg::ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_pos     <= '0;
            r_cnt     <= '0;
            r_count   <= '0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_cnt     <= n_cnt;
            r_count   <= n_count;
            r_hit     <= n_hit;
            r_free_ok <= n_free_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_value    <= n_value;
        r_hit_pos  <= n_hit_pos;
        r_hit_val  <= n_hit_val;
        r_free_pos <= n_free_pos;
    end

    a_no_rd_wr_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_ctl.rd && o_mem_ctl.wr))
        else $error("slot memory read and written in the same cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= AW'(LIMIT))
        else $error("entry count above half the capacity");

    a_insert_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_ctl.wr && o_wr_data[WW-1]) |-> (r_count < AW'(LIMIT)))
        else $error("entry stored at the load limit");

    a_home_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mod_done |-> ({1'b0, i_home} < (AW + 1)'(CAPACITY)))
        else $error("home slot outside the table");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_load |-> (i_out_free && r_state == S_DONE))
        else $error("result loaded while the output register is busy");

endmodule
